/* sv/mpws_pkg.sv */
package mpws_pkg;

  localparam int NumPatterns   = 8;
  localparam int MaxPatternLen = 32;
  localparam int SlotW         = 3;
  localparam int PosW          = 5;
  localparam int LenW          = 6;
  localparam int AddrW         = 48;
  localparam int EntryW        = 9;
  localparam int PatDepth      = NumPatterns * MaxPatternLen;
  localparam int PatAw         = SlotW + PosW;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SCAN   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_DONE,
    ST_REPORT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // write pattern byte/length
    logic             clear;     // clear scan state
    logic             shift;     // push image byte
    logic             rd_en;     // read pattern entry at (slot, pos)
    logic [SlotW-1:0] slot;
    logic [PosW-1:0]  pos;
    logic             cmp;       // compare last read entry
    logic             commit;    // record matches for all slots
    logic             emit;      // drive a report word
    logic             emit_last;
  } mpws_cmd_t;

endpackage

/* sv/mpws_ram.sv */
module mpws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* sv/mpws_ctrl.sv */
module mpws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mpws_pkg::cmd_t      in_cmd,
  output logic                busy,
  output mpws_pkg::mpws_cmd_t cmd
);
  import mpws_pkg::*;

  state_t state_r, state_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic             rd_v_r, rd_v_nxt;

  localparam logic [PosW-1:0]  PosMax  = PosW'(MaxPatternLen - 1);
  localparam logic [SlotW-1:0] SlotMax = SlotW'(NumPatterns - 1);

  // Scan: one pattern entry is read per cycle; walk positions,
  // in each position walk slots. Read is registered, compared in the next cycle.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    slot_nxt  = slot_r;
    rd_v_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        pos_nxt  = '0;
        slot_nxt = '0;
        if (start) begin
          case (in_cmd)
            CMD_SCAN:   state_nxt = ST_SCAN_RD;
            CMD_REPORT: state_nxt = ST_REPORT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: begin
        rd_v_nxt = 1'b1;
        if (slot_r == SlotMax) begin
          slot_nxt = '0;
          if (pos_r == PosMax) begin
            state_nxt = ST_SCAN_CMP;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_SCAN_CMP:  state_nxt = ST_SCAN_DONE;
      ST_SCAN_DONE: state_nxt = ST_IDLE;
      ST_REPORT: begin
        if (slot_r == SlotMax) begin
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    busy          = (state_r != ST_IDLE);
    cmd.slot      = slot_r;
    cmd.pos       = pos_r;
    cmd.cmp       = rd_v_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load  = start && (in_cmd == CMD_LOAD);
        cmd.clear = start && (in_cmd == CMD_CLEAR);
        cmd.shift = start && (in_cmd == CMD_SCAN);
      end
      ST_SCAN_RD:   cmd.rd_en = 1'b1;
      ST_SCAN_DONE: cmd.commit = 1'b1;
      ST_REPORT: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = (slot_r == SlotMax);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      slot_r  <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      slot_r  <= slot_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end
endmodule

/* sv/mpws_dp.sv */
module mpws_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mpws_pkg::mpws_cmd_t            cmd,
  input  logic [mpws_pkg::SlotW-1:0]     in_slot,
  input  logic [mpws_pkg::PosW-1:0]      in_pos,
  input  logic [7:0]                     in_byte,
  input  logic                           in_wild,
  input  logic [mpws_pkg::LenW-1:0]      in_len,
  input  logic                           cfg_we,
  input  logic [mpws_pkg::AddrW-1:0]     cfg_wdata,
  output logic                           out_valid,
  output logic [mpws_pkg::SlotW-1:0]     out_slot,
  output logic                           out_found,
  output logic [mpws_pkg::AddrW-1:0]     out_addr,
  output logic                           out_last
);
  import mpws_pkg::*;

  localparam logic [AddrW-1:0] CntMax = {AddrW{1'b1}};

  logic [AddrW-1:0]  base_r;
  logic [LenW-1:0]   len_r   [NumPatterns];
  logic              found_r [NumPatterns];
  logic [AddrW-1:0]  faddr_r [NumPatterns];
  logic [7:0]        win_r   [MaxPatternLen];
  logic [AddrW-1:0]  seen_r;
  logic              ok_r    [NumPatterns];   // running compare result
  logic [EntryW-1:0] rdata;
  logic [SlotW-1:0]  cmp_slot_r;
  logic [PosW-1:0]   cmp_pos_r;
  logic [LenW-1:0]   sat_len;
  logic [LenW-1:0]   cl;
  logic              pos_in;
  logic [LenW-1:0]   widx;
  logic              hit;

  assign sat_len = (in_len > LenW'(MaxPatternLen)) ? LenW'(MaxPatternLen) : in_len;

  mpws_ram #(.Width(EntryW), .Depth(PatDepth)) u_pat (
    .clk   (clk),
    .we    (cmd.load),
    .waddr ({in_slot, in_pos}),
    .wdata ({in_wild, in_byte}),
    .re    (cmd.rd_en),
    .raddr ({cmd.slot, cmd.pos}),
    .rdata (rdata)
  );

  // Position p of slot s compares with window[len-1-p], for p < len only.
  assign cl     = len_r[cmp_slot_r];
  assign pos_in = ({1'b0, cmp_pos_r} < cl);
  assign widx   = cl - 1'b1 - LenW'(cmp_pos_r);
  assign hit    = rdata[8] || (rdata[7:0] == win_r[widx[PosW-1:0]]);

  always_ff @(posedge clk) begin
    cmp_slot_r <= cmd.slot;
    cmp_pos_r  <= cmd.pos;
    if (!rst_n) begin
      base_r <= '0;
      seen_r <= '0;
      for (int i = 0; i < NumPatterns; i++) begin
        len_r[i]   <= '0;
        found_r[i] <= 1'b0;
        faddr_r[i] <= '0;
      end
      for (int i = 0; i < MaxPatternLen; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (cmd.load) begin
        len_r[in_slot]   <= sat_len;
        found_r[in_slot] <= 1'b0;
        faddr_r[in_slot] <= '0;
      end
      if (cmd.clear) begin
        seen_r <= '0;
        for (int i = 0; i < NumPatterns; i++) begin
          found_r[i] <= 1'b0;
          faddr_r[i] <= '0;
        end
        for (int i = 0; i < MaxPatternLen; i++) begin
          win_r[i] <= '0;
        end
      end
      if (cmd.shift) begin
        win_r[0] <= in_byte;
        for (int i = 1; i < MaxPatternLen; i++) begin
          win_r[i] <= win_r[i-1];
        end
        if (seen_r != CntMax) begin
          seen_r <= seen_r + 1'b1;
        end
        for (int i = 0; i < NumPatterns; i++) begin
          ok_r[i] <= 1'b1;
        end
      end
      if (cmd.cmp && pos_in && !hit) begin
        ok_r[cmp_slot_r] <= 1'b0;
      end
      if (cmd.commit) begin
        for (int i = 0; i < NumPatterns; i++) begin
          if (ok_r[i] && !found_r[i] && (len_r[i] != '0) &&
              (seen_r >= AddrW'(len_r[i]))) begin
            found_r[i] <= 1'b1;
            faddr_r[i] <= base_r + seen_r - AddrW'(len_r[i]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    out_slot  <= cmd.slot;
    out_found <= found_r[cmd.slot];
    out_addr  <= found_r[cmd.slot] ? faddr_r[cmd.slot] : '0;
    out_last  <= cmd.emit_last;
  end
endmodule

/* sv/multi_pattern_wildcard_scanner.sv */
// Wildcard byte signature scanner.
// Input: pulse start with in_command and its fields while busy is low.
//   LOAD writes one pattern byte (+wildcard mark) and sets the slot length,
//   clearing that slot's found state. CLEAR restarts the scan, keeps patterns.
//   SCAN pushes one image byte through the 32-byte window. REPORT emits one
//   word per slot.
// Timing: LOAD and CLEAR leave busy low. SCAN holds busy while the pattern
//   memory, which has one read port, has all 8 x 32 entries read one per
//   cycle; then the last read is compared and matches are committed.
//   REPORT holds busy while it steps the slots; each word appears in the
//   cycle after its report step, marked by out_valid, with out_last on slot 7.
// Results: one out_valid cycle per word; the receiver cannot stall, so the
//   words must be taken as they come.
// Config: cfg_we/cfg_wdata write image_base; write only while idle.
// Reset (rst_n low, synchronous): lengths, found flags, window, byte count
//   and image_base clear. Pattern memory is not cleared.
module multi_pattern_wildcard_scanner (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_command,
  input  logic [mpws_pkg::SlotW-1:0] in_pattern_slot,
  input  logic [mpws_pkg::PosW-1:0]  in_byte_position,
  input  logic [7:0]                 in_byte_value,
  input  logic                       in_is_wildcard,
  input  logic [mpws_pkg::LenW-1:0]  in_pattern_length,
  input  logic                       cfg_we,
  input  logic [mpws_pkg::AddrW-1:0] cfg_wdata,
  output logic                       out_valid,
  output logic [mpws_pkg::SlotW-1:0] out_result_slot,
  output logic                       out_found,
  output logic [mpws_pkg::AddrW-1:0] out_match_address,
  output logic                       out_last
);
  import mpws_pkg::*;

  mpws_cmd_t cmd;

  mpws_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (cmd_t'(in_command)),
    .busy   (busy),
    .cmd    (cmd)
  );

  mpws_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_slot   (in_pattern_slot),
    .in_pos    (in_byte_position),
    .in_byte   (in_byte_value),
    .in_wild   (in_is_wildcard),
    .in_len    (in_pattern_length),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_slot  (out_result_slot),
    .out_found (out_found),
    .out_addr  (out_match_address),
    .out_last  (out_last)
  );
endmodule

/* sv/mpws_checker.sv */
module mpws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_found,
  input logic [47:0] out_match_address,
  input logic        out_last
);
  ap_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without valid");
  ap_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_address == '0))
    else $error("address without match");
  ap_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy) else $error("word outside report");
  ap_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid) else $error("word after last");
endmodule

bind multi_pattern_wildcard_scanner mpws_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_found(out_found), .out_match_address(out_match_address), .out_last(out_last)
);
